// ===== sv/mgcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mgcr_pkg
// Shared types, port and CRTC register codes and the cursor scan line table
// for the monochrome graphics card register window.
// ----------------------------------------------------------------------------
package mgcr_pkg;

   // Number of CRTC registers and the index width that follows from it.
   localparam int CrtcRegs = 16;
   localparam int CrtcIdxW = $clog2(CrtcRegs);

   // Port offsets within the 16-byte window.
   localparam logic [3:0] PortIndex  = 4'd0;
   localparam logic [3:0] PortData   = 4'd1;
   localparam logic [3:0] PortMode   = 4'd4;
   localparam logic [3:0] PortStatus = 4'd6;
   localparam logic [3:0] PortEnable = 4'd11;

   // CRTC register indexes acted upon.
   localparam logic [CrtcIdxW-1:0] RegCursorStart = CrtcIdxW'(10);
   localparam logic [CrtcIdxW-1:0] RegCursorEnd   = CrtcIdxW'(11);
   localparam logic [CrtcIdxW-1:0] RegStartHigh   = CrtcIdxW'(12);
   localparam logic [CrtcIdxW-1:0] RegStartLow    = CrtcIdxW'(13);
   localparam logic [CrtcIdxW-1:0] RegCursorLow   = CrtcIdxW'(15);
   localparam logic [CrtcIdxW-1:0] RegCursorHigh  = CrtcIdxW'(14);

   // Screen geometry and cursor limits.
   localparam logic [7:0]  ScanMax     = 8'd13;
   localparam logic [10:0] ScreenCells = 11'd2000;
   // 2^20 / 80 rounded up: exact for every quotient below 2000 / 80.
   localparam logic [13:0] RecipCols   = 14'd13108;
   localparam logic [7:0]  NoPort      = 8'hff;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // One bus access.
   typedef struct packed {
      op_type     opcode;
      logic [3:0] port_offset;
      logic [7:0] write_data;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [7:0]  read_data;
      logic        graphics_mode;
      logic        page_select;
      logic [15:0] display_start;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic        cursor_enabled;
      logic [7:0]  cursor_top;
      logic [7:0]  cursor_bottom;
      logic        redraw;
   } rsp_type;

   // Scan line 0..13 scaled to 0..255 as (255 * s + 6) / 13.
   function automatic logic [7:0] scale_line(input logic [3:0] s);
      logic [7:0] r;
      case (s)
         4'd0:    r = 8'd0;
         4'd1:    r = 8'd20;
         4'd2:    r = 8'd39;
         4'd3:    r = 8'd59;
         4'd4:    r = 8'd78;
         4'd5:    r = 8'd98;
         4'd6:    r = 8'd118;
         4'd7:    r = 8'd137;
         4'd8:    r = 8'd157;
         4'd9:    r = 8'd177;
         4'd10:   r = 8'd196;
         4'd11:   r = 8'd216;
         4'd12:   r = 8'd235;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/mgcr_in_stage.sv =====
// ----------------------------------------------------------------------------
// mgcr_in_stage
// Input register: holds one accepted bus access until the core takes it.
// ----------------------------------------------------------------------------
module mgcr_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mgcr_pkg::req_type req_word,
   input  logic             advance,
   output logic             hold_valid,
   output mgcr_pkg::req_type hold_word
);
   import mgcr_pkg::*;

   logic    valid_ff, valid_in;
   req_type word_ff;
   logic    accept;

   // The register frees up whenever the core takes its word.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_word  = word_ff;

endmodule

// ===== sv/mgcr_core.sv =====
// ----------------------------------------------------------------------------
// mgcr_core
// Register state of the card: port latches, CRTC file, mode, cursor and
// status counter. Applies one bus access per cycle while the result register can take it, and forms its result.
// ----------------------------------------------------------------------------
module mgcr_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              fire,
   input  mgcr_pkg::req_type word,
   output mgcr_pkg::rsp_type result
);
   import mgcr_pkg::*;

   // State registers.
   logic [7:0]          file_ff [CrtcRegs];
   logic [7:0]          file_in [CrtcRegs];
   logic [7:0]          idx_ff, idx_in;
   logic [7:0]          stat_ff, stat_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                mode_ff, mode_in;
   logic                page_ff, page_in;
   logic                allow_g_ff, allow_g_in;
   logic                allow_p_ff, allow_p_in;
   logic                full_mem_ff;
   logic                cur_en_ff, cur_en_in;
   logic [7:0]          cur_top_ff, cur_top_in;
   logic [7:0]          cur_bot_ff, cur_bot_in;
   logic [6:0]          col_ff, col_in;
   logic [4:0]          row_ff, row_in;

   // Decode.
   logic                in_range;
   logic [CrtcIdxW-1:0] reg_sel;
   logic                crtc_wr;
   logic [7:0]          rd;
   logic                redraw;
   logic                nm, np;
   logic [15:0]         start_old, start_new;

   // Cursor shape and position.
   logic [7:0]          y1, y2;
   logic [3:0]          y2_eff;
   logic [15:0]         pos, rel;
   logic                pos_ok;
   logic [24:0]         prod;
   logic [4:0]          quo;
   logic [10:0]         quo_x80;
   logic [10:0]         rem;

   assign in_range = idx_ff < 8'(CrtcRegs);
   assign reg_sel  = idx_ff[CrtcIdxW-1:0];
   assign crtc_wr  = fire && word.opcode == OP_WRITE && word.port_offset == PortData
                     && in_range;

   // CRTC file with this access's write applied.
   always_comb begin
      for (int i = 0; i < CrtcRegs; i++) begin
         file_in[i] = file_ff[i];
      end
      if (crtc_wr) begin
         file_in[reg_sel] = word.write_data;
      end
   end

   assign start_old = {file_ff[RegStartHigh], file_ff[RegStartLow]};
   assign start_new = {file_in[RegStartHigh], file_in[RegStartLow]};

   // Cursor shape from the start and end scan lines.
   assign y1     = file_in[RegCursorStart];
   assign y2     = file_in[RegCursorEnd];
   assign y2_eff = (y2 < y1 || y2 > ScanMax) ? ScanMax[3:0] : y2[3:0];

   // Cursor cell relative to the display start, split into row and column.
   assign pos     = {file_in[RegCursorHigh], file_in[RegCursorLow]};
   assign rel     = pos - start_new;
   assign pos_ok  = pos >= start_new && rel < 16'(ScreenCells);
   assign prod    = rel[10:0] * RecipCols;
   assign quo     = prod[24:20];
   assign quo_x80 = {quo, 6'd0} + {2'd0, quo, 4'd0};
   assign rem     = rel[10:0] - quo_x80;

   // Mode and page requested by a port 4 write.
   assign nm = allow_g_ff && word.write_data[1];
   assign np = allow_p_ff && full_mem_ff && word.write_data[7];

   // Next state, read data and redraw flag.
   always_comb begin
      idx_in     = idx_ff;
      stat_in    = stat_ff;
      cnt_in     = cnt_ff;
      mode_in    = mode_ff;
      page_in    = page_ff;
      allow_g_in = allow_g_ff;
      allow_p_in = allow_p_ff;
      cur_en_in  = cur_en_ff;
      cur_top_in = cur_top_ff;
      cur_bot_in = cur_bot_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      rd         = '0;
      redraw     = 1'b0;
      if (fire && word.opcode == OP_WRITE) begin
         case (word.port_offset)
            PortIndex: idx_in = word.write_data;
            PortData: begin
               if (in_range) begin
                  case (reg_sel)
                     RegCursorStart, RegCursorEnd: begin
                        if (!mode_ff) begin
                           if (y1 > ScanMax) begin
                              cur_en_in  = 1'b0;
                              cur_top_in = '0;
                              cur_bot_in = '0;
                           end else begin
                              cur_en_in  = 1'b1;
                              cur_top_in = scale_line(y1[3:0]);
                              cur_bot_in = scale_line(y2_eff);
                           end
                        end
                     end
                     RegStartHigh, RegStartLow: begin
                        redraw = start_new != start_old && !mode_ff;
                     end
                     RegCursorLow: begin
                        if (!mode_ff && pos_ok) begin
                           col_in = rem[6:0];
                           row_in = quo;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            PortMode: begin
               mode_in = nm;
               page_in = np;
               redraw  = nm != mode_ff || np != page_ff;
            end
            PortStatus: stat_in = word.write_data;
            PortEnable: begin
               allow_g_in = word.write_data[0];
               allow_p_in = word.write_data[1];
            end
            default: ;
         endcase
      end else if (fire) begin
         case (word.port_offset)
            PortIndex: rd = idx_ff;
            PortData:  rd = in_range ? file_ff[reg_sel] : NoPort;
            PortStatus: begin
               // Bit 0 toggles every 8 reads, bit 7 every 64.
               cnt_in = cnt_ff + 6'd1;
               if (cnt_in[2:0] == 3'd0) begin
                  stat_in[0] = ~stat_ff[0];
               end
               if (cnt_in == 6'd0) begin
                  stat_in[7] = ~stat_ff[7];
               end
               rd = stat_in;
            end
            default: rd = NoPort;
         endcase
      end
   end

   // State registers, all set to their start values by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CrtcRegs; i++) begin
            file_ff[i] <= '0;
         end
         idx_ff      <= '0;
         stat_ff     <= '0;
         cnt_ff      <= '0;
         mode_ff     <= 1'b0;
         page_ff     <= 1'b0;
         allow_g_ff  <= 1'b0;
         allow_p_ff  <= 1'b0;
         full_mem_ff <= 1'b1;
         cur_en_ff   <= 1'b1;
         cur_top_ff  <= '0;
         cur_bot_ff  <= 8'hff;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         for (int i = 0; i < CrtcRegs; i++) begin
            file_ff[i] <= file_in[i];
         end
         idx_ff     <= idx_in;
         stat_ff    <= stat_in;
         cnt_ff     <= cnt_in;
         mode_ff    <= mode_in;
         page_ff    <= page_in;
         allow_g_ff <= allow_g_in;
         allow_p_ff <= allow_p_in;
         cur_en_ff  <= cur_en_in;
         cur_top_ff <= cur_top_in;
         cur_bot_ff <= cur_bot_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         if (csr_wr_en) begin
            full_mem_ff <= csr_wr_data;
         end
      end
   end

   // The result shows the state after this access.
   always_comb begin
      result.read_data      = rd;
      result.graphics_mode  = mode_in;
      result.page_select    = page_in;
      result.display_start  = start_new;
      result.cursor_col     = col_in;
      result.cursor_row     = row_in;
      result.cursor_enabled = cur_en_in;
      result.cursor_top     = cur_top_in;
      result.cursor_bottom  = cur_bot_in;
      result.redraw         = redraw;
   end

endmodule

// ===== sv/mgcr_out_stage.sv =====
// ----------------------------------------------------------------------------
// mgcr_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module mgcr_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  mgcr_pkg::rsp_type result,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mgcr_pkg::rsp_type rsp_word
);
   import mgcr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type word_ff;

   // A new word may enter when the register is empty or being emptied.
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== sv/mono_graphics_card_registers.sv =====
// ----------------------------------------------------------------------------
// mono_graphics_card_registers
// Register window of a monochrome graphics card with a 6845-style CRTC.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one byte read or write to the 16-port
// window. Each access gives exactly one word on the rsp_ channel carrying the
// read byte and the display state after the access: mode, page, display
// start, cursor position and shape, and a redraw flag.
// An access is registered in the input register on entry and applied to the
// register state once the result register can take it; its result is
// registered in the result register as the state registers update.
// One access is taken every cycle unless rsp_stall holds a waiting result;
// the state registers apply each access as it leaves the input register.
// When rsp_stall holds a waiting result, the accepted access behind it waits
// in the input register and req_stall rises; both sides resume without loss.
// The csr_ port writes the memory size bit; write it only while idle.
// Reset sets the control registers to their start values: text mode, page zero,
// cursor shown over the full cell, and memory size set to full.
// ----------------------------------------------------------------------------
module mono_graphics_card_registers (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [3:0] req_port_offset,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_graphics_mode,
   output logic       rsp_page_select,
   output logic [15:0] rsp_display_start,
   output logic [6:0] rsp_cursor_col,
   output logic [4:0] rsp_cursor_row,
   output logic       rsp_cursor_enabled,
   output logic [7:0] rsp_cursor_top,
   output logic [7:0] rsp_cursor_bottom,
   output logic       rsp_redraw
);
   import mgcr_pkg::*;

   req_type req_word, hold_word;
   rsp_type result, rsp_word;
   logic    hold_valid, advance, fire;

   // Pack the input fields.
   always_comb begin
      req_word.opcode      = op_type'(req_opcode);
      req_word.port_offset = req_port_offset;
      req_word.write_data  = req_write_data;
   end

   assign fire = hold_valid && advance;

   mgcr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_word  (hold_word)
   );

   mgcr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .word        (hold_word),
      .result      (result)
   );

   mgcr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Unpack the result fields.
   assign rsp_read_data      = rsp_word.read_data;
   assign rsp_graphics_mode  = rsp_word.graphics_mode;
   assign rsp_page_select    = rsp_word.page_select;
   assign rsp_display_start  = rsp_word.display_start;
   assign rsp_cursor_col     = rsp_word.cursor_col;
   assign rsp_cursor_row     = rsp_word.cursor_row;
   assign rsp_cursor_enabled = rsp_word.cursor_enabled;
   assign rsp_cursor_top     = rsp_word.cursor_top;
   assign rsp_cursor_bottom  = rsp_word.cursor_bottom;
   assign rsp_redraw         = rsp_word.redraw;

endmodule
